FILE: sv/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// types, command and status codes shared by the deque with middle insert
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_INSERT_MID = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_POP_BACK   = 3'd4;
   localparam logic [2:0] CMD_CLEAR      = 3'd5;
   localparam logic [2:0] CMD_READ       = 3'd6;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
      logic [5:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic [6:0]         occupancy;
   } rsp_type;

endpackage

FILE: sv/bounded_deque_with_middle_insert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_middle_insert_unit
// circular list of signed 32-bit entries in one single-port-write memory
// ----------------------------------------------------------------------------
// pushes, clear and failed commands give their result in the cycle after the
//   request; pops and reads go through the memory read register and S_DATA
// middle insert: S_SHIFT moves entries one place back, one entry per cycle,
//   through the memory read and write ports, then S_INSERT writes; busy is high meanwhile
// a new request is taken in the cycle a result is shown; results cannot stall
// reset clears head, count and control; the entry memory has no clearing pass
module bounded_deque_with_middle_insert_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bdq_pkg::req_type  req_item,
   output logic              rsp_valid,
   output bdq_pkg::rsp_type  rsp_item
);

   localparam int IDX_W = bdq_pkg::IDX_W;
   localparam int CNT_W = bdq_pkg::CNT_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DATA   = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_INSERT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  shift_idx_ff, shift_idx_in;
   bdq_pkg::req_type  req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bdq_pkg::rsp_type  rsp_ff, rsp_in;

   logic [31:0]       mem [bdq_pkg::CAPACITY];
   logic [31:0]       rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [31:0]       mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;

   logic              accept;
   logic              full;
   logic              empty;
   logic [IDX_W-1:0]  tail_idx;
   logic [IDX_W-1:0]  last_idx;
   logic [IDX_W-1:0]  mid_idx;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign full     = (count_ff == CNT_W'(bdq_pkg::CAPACITY));
   assign empty    = (count_ff == '0);
   assign tail_idx = IDX_W'(count_ff);
   assign last_idx = IDX_W'(count_ff - 1'b1);
   // insert point: count/2, or the end of the list below two entries
   assign mid_idx  = (count_ff < CNT_W'(2)) ? IDX_W'(count_ff) : IDX_W'(count_ff >> 1);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      shift_idx_in = shift_idx_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = head_ff + tail_idx;
      mem_wdata    = req_ff.value;
      mem_raddr    = head_ff;

      case (state_ff)
         S_IDLE: begin
            case (req_item.cmd)
               bdq_pkg::CMD_POP_BACK:   mem_raddr = head_ff + last_idx;
               bdq_pkg::CMD_READ:       mem_raddr = head_ff + IDX_W'(req_item.position);
               bdq_pkg::CMD_INSERT_MID: mem_raddr = head_ff + last_idx;
               default:                 mem_raddr = head_ff;
            endcase
            if (accept) begin
               req_in             = req_item;
               rsp_in.status      = bdq_pkg::STATUS_OK;
               rsp_in.data_out    = '0;
               rsp_in.occupancy   = 7'(count_ff);
               rsp_valid_in       = 1'b1;
               case (req_item.cmd)
                  bdq_pkg::CMD_PUSH_FRONT: begin
                     if (full) begin
                        rsp_in.status = bdq_pkg::STATUS_FULL;
                     end else begin
                        head_in          = head_ff - 1'b1;
                        mem_we           = 1'b1;
                        mem_waddr        = head_ff - 1'b1;
                        mem_wdata        = req_item.value;
                        count_in         = count_ff + 1'b1;
                        rsp_in.occupancy = 7'(count_in);
                     end
                  end
                  bdq_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        rsp_in.status = bdq_pkg::STATUS_FULL;
                     end else begin
                        mem_we           = 1'b1;
                        mem_waddr        = head_ff + tail_idx;
                        mem_wdata        = req_item.value;
                        count_in         = count_ff + 1'b1;
                        rsp_in.occupancy = 7'(count_in);
                     end
                  end
                  bdq_pkg::CMD_INSERT_MID: begin
                     if (full) begin
                        rsp_in.status = bdq_pkg::STATUS_FULL;
                     end else if (count_ff < CNT_W'(2)) begin
                        mem_we           = 1'b1;
                        mem_waddr        = head_ff + tail_idx;
                        mem_wdata        = req_item.value;
                        count_in         = count_ff + 1'b1;
                        rsp_in.occupancy = 7'(count_in);
                     end else begin
                        // last entry is being read; move entries back from there
                        rsp_valid_in = 1'b0;
                        shift_idx_in = last_idx;
                        state_in     = S_SHIFT;
                     end
                  end
                  bdq_pkg::CMD_POP_FRONT: begin
                     if (empty) begin
                        rsp_in.status = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        head_in      = head_ff + 1'b1;
                        count_in     = count_ff - 1'b1;
                        state_in     = S_DATA;
                     end
                  end
                  bdq_pkg::CMD_POP_BACK: begin
                     if (empty) begin
                        rsp_in.status = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        count_in     = count_ff - 1'b1;
                        state_in     = S_DATA;
                     end
                  end
                  bdq_pkg::CMD_CLEAR: begin
                     head_in          = '0;
                     count_in         = '0;
                     rsp_in.occupancy = '0;
                  end
                  bdq_pkg::CMD_READ: begin
                     if (CNT_W'(req_item.position) >= count_ff) begin
                        rsp_in.status = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_DATA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DATA: begin
            rsp_valid_in     = 1'b1;
            rsp_in.status    = bdq_pkg::STATUS_OK;
            rsp_in.data_out  = rd_data_ff;
            rsp_in.occupancy = 7'(count_ff);
            state_in         = S_IDLE;
         end
         S_SHIFT: begin
            // write the entry read last cycle one place back, read the next one
            mem_we    = 1'b1;
            mem_waddr = head_ff + shift_idx_ff + 1'b1;
            mem_wdata = rd_data_ff;
            mem_raddr = head_ff + shift_idx_ff - 1'b1;
            if (shift_idx_ff == mid_idx) begin
               state_in = S_INSERT;
            end else begin
               shift_idx_in = shift_idx_ff - 1'b1;
            end
         end
         S_INSERT: begin
            mem_we           = 1'b1;
            mem_waddr        = head_ff + mid_idx;
            mem_wdata        = req_ff.value;
            count_in         = count_ff + 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_in.status    = bdq_pkg::STATUS_OK;
            rsp_in.data_out  = '0;
            rsp_in.occupancy = 7'(count_in);
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_idx_ff <= shift_idx_in;
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(bdq_pkg::CAPACITY))
      else $error("entry count beyond capacity");

   a_shift_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (!full && shift_idx_ff >= mid_idx))
      else $error("shift index below insert point or list full");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(accept) || $past(state_ff == S_DATA)
                        || $past(state_ff == S_INSERT)))
      else $error("result without a request behind it");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("middle insert did not grow the list");
`endif

endmodule
